### rtl/core/mlds_pkg.sv
// ----------------------------------------------------------------------------
// mlds_pkg
// Shared types and constants of the mip level downsampler.
// ----------------------------------------------------------------------------
package mlds_pkg;

    localparam int CHAN_W         = 16;
    localparam int DEST_W         = 11;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CNT_CFG_W      = 3;
    localparam int MAX_SRC_HEIGHT = 4096;
    localparam int ROW_W          = 12;   // source row index
    localparam int VCOEF_W        = 13;   // clamped height and vertical weights
    localparam int QUOT_W         = 16;
    localparam int QCNT_W         = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic clr;       // restart level: zero horizontal sum
        logic load;      // capture source pixel
        logic mul1;      // horizontal products
        logic hadd;      // horizontal sum
        logic hwe;       // update horizontal running sum
        logic hacc_add;  // add to it rather than replace
        logic mul2;      // vertical products
        logic vadd;      // vertical sum
        logic vwe;       // update column accumulator
        logic vacc_add;
        logic dinit;     // divider start
        logic dstep;     // divider iteration
    } t_lane_ctl;

endpackage

### rtl/core/mipmap_level_downsample.sv
// ----------------------------------------------------------------------------
// mipmap_level_downsample
// Box/3-tap downsample of one source mip level streamed in raster order.
// ----------------------------------------------------------------------------
// Each source pixel passes the states MUL1, HADD, MUL2 and VADD; one that
// completes a result then goes through DINIT, the 16-step divider and PUT into
// the output register, where PUT waits while a held result is stalled. A new
// source pixel is taken only once the last one is through (o_in_stall).
// Reset: sizes go to 2x2, four channels, raster position and horizontal sums
// to zero. The column accumulator memory is not cleared.
module mipmap_level_downsample #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int MAX_CHANNELS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mlds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlds_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mlds_pkg::CHAN_W-1:0]    i_chan0_in,
    input  logic [mlds_pkg::CHAN_W-1:0]    i_chan1_in,
    input  logic [mlds_pkg::CHAN_W-1:0]    i_chan2_in,
    input  logic [mlds_pkg::CHAN_W-1:0]    i_chan3_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mlds_pkg::CHAN_W-1:0]    o_chan0_out,
    output logic [mlds_pkg::CHAN_W-1:0]    o_chan1_out,
    output logic [mlds_pkg::CHAN_W-1:0]    o_chan2_out,
    output logic [mlds_pkg::CHAN_W-1:0]    o_chan3_out,
    output logic [mlds_pkg::DEST_W-1:0]    o_dest_x,
    output logic [mlds_pkg::DEST_W-1:0]    o_dest_y,
    output logic                          o_level_done
);
    import mlds_pkg::*;

    localparam int CW   = $clog2(MAX_SRC_WIDTH + 1);   // clamped width
    localparam int COLW = $clog2(MAX_SRC_WIDTH);       // source column
    localparam int COLS = MAX_SRC_WIDTH / 2;
    localparam int XW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DNW  = CW + VCOEF_W;
    localparam int NPORT = 4;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_HADD, S_MUL2, S_VADD, S_DINIT, S_DIV, S_PUT
    } t_state;

    t_state r_state;
    logic [CFG_W-1:0]     r_src_width, r_src_height;
    logic [CNT_CFG_W-1:0] r_channel_count;
    logic [COLW-1:0]      r_col;
    logic [ROW_W-1:0]     r_row;
    logic [QCNT_W-1:0]    r_qcnt;
    logic [CW-1:0]        r_hm1, r_hm2;
    logic [VCOEF_W-1:0]   r_vm1, r_vm2;
    logic [XW-1:0]        r_hx;
    logic [ROW_W-1:0]     r_vy;
    logic                 r_last, r_hwe, r_hacc_add, r_vwe, r_vacc_add, r_vdone;
    logic [DNW-1:0]       r_den;
    logic                 r_out_valid, r_done;
    logic [XW-1:0]        r_dx;
    logic [ROW_W-1:0]     r_dy;
    logic [CHAN_W-1:0]    r_q [NPORT];

    logic [CW-1:0]        sw, dw, n_c1;
    logic [VCOEF_W-1:0]   sh, dh, n_r1;
    logic [2:0]           nc;
    logic [COLW-1:0]      c;
    logic [ROW_W-1:0]     r;
    logic [CW-1:0]        x;
    logic [VCOEF_W-1:0]   y;
    logic                 oddw, oddh, hdone, vdone, in_xfer, out_xfer, restart;
    logic [CW-1:0]        hm1, hm2;
    logic [VCOEF_W-1:0]   vm1, vm2;
    logic                 hwe, hacc_add, vwe, vacc_add;
    logic [CW-1:0]        hx;
    logic [VCOEF_W-1:0]   vy;
    t_lane_ctl            ctl;
    logic [CHAN_W-1:0]    pix  [NPORT];
    logic [CHAN_W-1:0]    quot [NPORT];

    assign pix[0] = i_chan0_in;
    assign pix[1] = i_chan1_in;
    assign pix[2] = i_chan2_in;
    assign pix[3] = i_chan3_in;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_xfer = r_out_valid && !i_out_stall;
    assign restart  = i_cfg_we && (i_cfg_index == CFG_SRC_WIDTH ||
                      i_cfg_index == CFG_SRC_HEIGHT || i_cfg_index == CFG_CHANNEL_COUNT);

    // saturate the sizes into their legal ranges
    always_comb begin
        if (r_src_width < CFG_W'(2))
            sw = CW'(2);
        else if (32'(r_src_width) > 32'(MAX_SRC_WIDTH))
            sw = CW'(MAX_SRC_WIDTH);
        else
            sw = CW'(r_src_width);
        if (r_src_height < CFG_W'(2))
            sh = VCOEF_W'(2);
        else if (32'(r_src_height) > 32'(MAX_SRC_HEIGHT))
            sh = VCOEF_W'(MAX_SRC_HEIGHT);
        else
            sh = VCOEF_W'(r_src_height);
        if (r_channel_count == '0)
            nc = 3'd1;
        else if (32'(r_channel_count) > 32'(MAX_CHANNELS))
            nc = 3'(MAX_CHANNELS);
        else
            nc = r_channel_count;
    end

    assign dw   = sw >> 1;
    assign dh   = sh >> 1;
    assign oddw = sw[0];
    assign oddh = sh[0];

    always_comb begin
        if (CW'(r_col) >= sw || VCOEF_W'(r_row) >= sh) begin
            c = '0;
            r = '0;
        end else begin
            c = r_col;
            r = r_row;
        end
        x = CW'(c >> 1);
        y = VCOEF_W'(r >> 1);
        n_c1 = CW'(c) + CW'(1);
        n_r1 = VCOEF_W'(r) + VCOEF_W'(1);

        // horizontal taps
        hm1 = CW'(1); hm2 = CW'(1); hwe = 1'b0; hacc_add = 1'b0;
        hdone = 1'b0; hx = x;
        if (!oddw) begin
            if (!c[0]) begin
                hwe = 1'b1;
            end else begin
                hdone = 1'b1;
            end
        end else if (c[0]) begin
            hm2 = dw; hwe = 1'b1; hacc_add = 1'b1;
        end else begin
            hm1 = x; hdone = (x != '0); hx = x - CW'(1);
            hm2 = dw - x; hwe = (x < dw);
        end

        // vertical taps
        vm1 = VCOEF_W'(1); vm2 = VCOEF_W'(1); vwe = 1'b0; vacc_add = 1'b0;
        vdone = 1'b0; vy = y;
        if (!oddh) begin
            if (!r[0]) begin
                vwe = 1'b1;
            end else begin
                vdone = 1'b1;
            end
        end else if (r[0]) begin
            vm2 = dh; vwe = 1'b1; vacc_add = 1'b1;
        end else begin
            vm1 = y; vdone = (y != '0); vy = y - VCOEF_W'(1);
            vm2 = dh - y; vwe = (y < dh);
        end
        vwe   = vwe && hdone;
        vdone = vdone && hdone;
    end

    always_comb begin
        ctl          = '0;
        ctl.clr      = restart;
        ctl.load     = in_xfer;
        ctl.mul1     = (r_state == S_MUL1);
        ctl.hadd     = (r_state == S_HADD);
        ctl.hwe      = r_hwe;
        ctl.hacc_add = r_hacc_add;
        ctl.mul2     = (r_state == S_MUL2);
        ctl.vadd     = (r_state == S_VADD);
        ctl.vwe      = r_vwe;
        ctl.vacc_add = r_vacc_add;
        ctl.dinit    = (r_state == S_DINIT);
        ctl.dstep    = (r_state == S_DIV);
    end

    genvar g;
    generate
        for (g = 0; g < NPORT; g++) begin : g_lane
            if (g < MAX_CHANNELS) begin : g_on
                logic [CHAN_W-1:0] lane_pix;
                assign lane_pix = (3'(g) < nc) ? pix[g] : '0;
                mlds_lane #(
                    .HCOEF_W (CW),
                    .XW      (XW),
                    .COLS    (COLS)
                ) u_lane (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (ctl),
                    .i_pix   (lane_pix),
                    .i_hm1   (r_hm1),
                    .i_hm2   (r_hm2),
                    .i_vm1   (r_vm1),
                    .i_vm2   (r_vm2),
                    .i_hx    (r_hx),
                    .i_den   (r_den),
                    .o_quot  (quot[g])
                );
            end else begin : g_off
                assign quot[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_src_width     <= CFG_W'(2);
            r_src_height    <= CFG_W'(2);
            r_channel_count <= CNT_CFG_W'(4);
            r_col           <= '0;
            r_row           <= '0;
            r_out_valid     <= 1'b0;
            r_qcnt          <= '0;
        end else begin
            if (r_state == S_PUT && (!r_out_valid || !i_out_stall))
                r_out_valid <= 1'b1;
            else if (out_xfer)
                r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SRC_WIDTH:     r_src_width     <= i_cfg_data;
                    CFG_SRC_HEIGHT:    r_src_height    <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CNT_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (restart) begin
                r_col <= '0;
                r_row <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_hm1      <= hm1;
                        r_hm2      <= hm2;
                        r_vm1      <= vm1;
                        r_vm2      <= vm2;
                        r_hwe      <= hwe;
                        r_hacc_add <= hacc_add;
                        r_vwe      <= vwe;
                        r_vacc_add <= vacc_add;
                        r_vdone    <= vdone;
                        r_hx       <= XW'(hx);
                        r_vy       <= ROW_W'(vy);
                        r_last     <= (hx == dw - CW'(1)) && (vy == dh - VCOEF_W'(1));
                        r_den      <= DNW'(oddw ? sw : CW'(2)) *
                                      DNW'(oddh ? sh : VCOEF_W'(2));
                        // advance raster position
                        if (!restart) begin
                            if (n_c1 >= sw) begin
                                r_col <= '0;
                                r_row <= (n_r1 >= sh) ? '0 : ROW_W'(n_r1);
                            end else begin
                                r_col <= COLW'(n_c1);
                                r_row <= r;
                            end
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_HADD;
                S_HADD: r_state <= S_MUL2;
                S_MUL2: r_state <= S_VADD;
                S_VADD: r_state <= r_vdone ? S_DINIT : S_IDLE;
                S_DINIT: begin
                    r_qcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_qcnt <= r_qcnt + QCNT_W'(1);
                    if (r_qcnt == QCNT_W'(QUOT_W - 1)) r_state <= S_PUT;
                end
                S_PUT: begin
                    // merge lane results into the output register
                    if (!r_out_valid || !i_out_stall) begin
                        for (int k = 0; k < NPORT; k++) r_q[k] <= quot[k];
                        r_dx    <= r_hx;
                        r_dy    <= r_vy;
                        r_done  <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_chan0_out  = r_q[0];
    assign o_chan1_out  = r_q[1];
    assign o_chan2_out  = r_q[2];
    assign o_chan3_out  = r_q[3];
    assign o_dest_x     = DEST_W'(r_dx);
    assign o_dest_y     = DEST_W'(r_dy);
    assign o_level_done = r_done;

endmodule

### rtl/core/mlds_lane.sv
// ----------------------------------------------------------------------------
// mlds_lane
// One channel: horizontal and vertical weighted sums, column accumulator
// memory and a bit-serial rounding divider.
// ----------------------------------------------------------------------------
module mlds_lane #(
    parameter int HCOEF_W = 13,
    parameter int XW      = 11,
    parameter int COLS    = 2048
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mlds_pkg::t_lane_ctl       i_ctl,
    input  logic [mlds_pkg::CHAN_W-1:0]  i_pix,
    input  logic [HCOEF_W-1:0]        i_hm1,
    input  logic [HCOEF_W-1:0]        i_hm2,
    input  logic [mlds_pkg::VCOEF_W-1:0] i_vm1,
    input  logic [mlds_pkg::VCOEF_W-1:0] i_vm2,
    input  logic [XW-1:0]             i_hx,
    input  logic [HCOEF_W+mlds_pkg::VCOEF_W-1:0] i_den,
    output logic [mlds_pkg::QUOT_W-1:0]  o_quot
);
    import mlds_pkg::*;

    localparam int HW  = CHAN_W + HCOEF_W;
    localparam int VW  = HW + VCOEF_W;
    localparam int NW  = VW + 2;

    logic [CHAN_W-1:0]  r_pix;
    logic [HW-1:0]      r_prod1, r_prod2, r_hacc, r_hsum;
    logic [VW-1:0]      r_prod3, r_prod4, r_rdata, r_fin;
    logic [NW-1:0]      r_rem, r_dsh;
    logic [QUOT_W-1:0]  r_quot;
    logic [VW-1:0]      mem [COLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hacc <= '0;
        end else if (i_ctl.clr) begin
            r_hacc <= '0;
        end else if (i_ctl.hadd && i_ctl.hwe) begin
            r_hacc <= i_ctl.hacc_add ? HW'(r_hacc + r_prod2) : r_prod2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_pix <= i_pix;
        if (i_ctl.mul1) begin
            r_prod1 <= HW'(i_hm1) * HW'(r_pix);
            r_prod2 <= HW'(i_hm2) * HW'(r_pix);
        end
        if (i_ctl.hadd) r_hsum <= HW'(r_hacc + r_prod1);
        if (i_ctl.mul2) begin
            r_prod3 <= VW'(i_vm1) * VW'(r_hsum);
            r_prod4 <= VW'(i_vm2) * VW'(r_hsum);
        end
        if (i_ctl.vadd) r_fin <= VW'(r_rdata + r_prod3);
        if (i_ctl.dinit) begin
            r_rem  <= NW'({r_fin, 1'b0}) + NW'(i_den);
            r_dsh  <= NW'({i_den, 1'b0}) << (QUOT_W - 1);
            r_quot <= '0;
        end else if (i_ctl.dstep) begin
            if (r_rem >= r_dsh) begin
                r_rem  <= r_rem - r_dsh;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    // column accumulator memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.vadd && i_ctl.vwe)
            mem[i_hx] <= i_ctl.vacc_add ? VW'(r_rdata + r_prod4) : r_prod4;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_hx];
    end

    assign o_quot = r_quot;

endmodule

### dv/tb_mipmap_level_downsample.sv
// ----------------------------------------------------------------------------
// tb_mipmap_level_downsample
// Streams source mip levels of many sizes and channel counts through the
// downsampler, predicts each filtered destination pixel and checks every
// output transfer field by field, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_mipmap_level_downsample;
    timeunit 1ns;
    timeprecision 1ps;
    import mlds_pkg::*;

    localparam int ACC_COLS   = 2048;
    localparam int IDLE_LIMIT = 5000;

    typedef logic [3:0][CHAN_W-1:0] t_pix;

    typedef struct {
        t_pix              chans;
        logic [DEST_W-1:0] x;
        logic [DEST_W-1:0] y;
        logic              done;
    } t_dest_pix;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CHAN_W-1:0]    i_chan0_in = '0, i_chan1_in = '0, i_chan2_in = '0, i_chan3_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CHAN_W-1:0]    o_chan0_out, o_chan1_out, o_chan2_out, o_chan3_out;
    logic [DEST_W-1:0]    o_dest_x, o_dest_y;
    logic                 o_level_done;

    mipmap_level_downsample dut (.*);

    always #4 i_clk = ~i_clk;

    // downsampler state as predicted
    int unsigned  width_reg = 2, height_reg = 2, chan_reg = 4;
    logic [63:0]  col_sum [0:ACC_COLS*4-1];
    logic [31:0]  row_sum [4];
    int unsigned  src_col, src_row;

    t_pix      pixel_q[$];
    t_dest_pix dest_q[$];
    int        errors = 0;
    int        idle_cycles = 0;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // filter one accepted source pixel, queue a destination pixel if one completes
    task automatic filter_pixel(input t_pix px);
        int unsigned sw, sh, nc, dw, dh, c, r, x, y, hx, vy, k;
        bit          oddw, oddh, hdone, vdone;
        logic [63:0] p [4];
        logic [63:0] hs [4];
        logic [63:0] fin [4];
        logic [63:0] den;
        t_dest_pix   d;
        sw = clampu(width_reg, 2, 4096);
        sh = clampu(height_reg, 2, 4096);
        nc = clampu(chan_reg, 1, 4);
        dw = sw >> 1;
        dh = sh >> 1;
        oddw = sw[0];
        oddh = sh[0];
        c = src_col;
        r = src_row;
        hdone = 0;
        vdone = 0;
        hx = 0;
        vy = 0;
        if (c >= sw || r >= sh) begin
            c = 0;
            r = 0;
        end
        for (k = 0; k < 4; k++) begin
            p[k] = (k < nc) ? 64'(px[k]) : 64'd0;
            hs[k] = 0;
            fin[k] = 0;
        end
        x = c >> 1;
        if (!oddw) begin
            if (!c[0]) begin
                for (k = 0; k < 4; k++) row_sum[k] = 32'(p[k]);
            end else begin
                for (k = 0; k < 4; k++) hs[k] = row_sum[k] + p[k];
                hdone = 1;
                hx = x;
            end
        end else if (c[0]) begin
            for (k = 0; k < 4; k++) row_sum[k] = row_sum[k] + 32'(dw * p[k]);
        end else begin
            if (x > 0) begin
                for (k = 0; k < 4; k++) hs[k] = row_sum[k] + x * p[k];
                hdone = 1;
                hx = x - 1;
            end
            if (x < dw) begin
                for (k = 0; k < 4; k++) row_sum[k] = 32'((dw - x) * p[k]);
            end
        end
        if (hdone) begin
            y = r >> 1;
            for (k = 0; k < 4; k++) begin
                if (!oddh) begin
                    if (!r[0]) begin
                        col_sum[(hx % ACC_COLS) * 4 + k] = hs[k];
                    end else begin
                        fin[k] = col_sum[(hx % ACC_COLS) * 4 + k] + hs[k];
                        vdone = 1;
                        vy = y;
                    end
                end else if (r[0]) begin
                    col_sum[(hx % ACC_COLS) * 4 + k] += dh * hs[k];
                end else begin
                    if (y > 0) begin
                        fin[k] = col_sum[(hx % ACC_COLS) * 4 + k] + y * hs[k];
                        vdone = 1;
                        vy = y - 1;
                    end
                    if (y < dh) col_sum[(hx % ACC_COLS) * 4 + k] = (dh - y) * hs[k];
                end
            end
        end
        if (vdone) begin
            den = (oddw ? 64'(2 * dw + 1) : 64'd2) * (oddh ? 64'(2 * dh + 1) : 64'd2);
            for (k = 0; k < 4; k++) d.chans[k] = CHAN_W'((2 * fin[k] + den) / (2 * den));
            d.x = DEST_W'(hx);
            d.y = DEST_W'(vy);
            d.done = (hx == dw - 1 && vy == dh - 1);
            dest_q.push_back(d);
        end
        c++;
        if (c >= sw) begin
            c = 0;
            r++;
            if (r >= sh) r = 0;
        end
        src_col = c;
        src_row = r;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:     width_reg = val & 32'h1fff;
            CFG_SRC_HEIGHT:    height_reg = val & 32'h1fff;
            CFG_CHANNEL_COUNT: chan_reg = val & 32'h7;
            default: ;
        endcase
        src_col = 0;
        src_row = 0;
        for (int k = 0; k < 4; k++) row_sum[k] = 0;
    endtask

    // hold until every pixel is sent and every result is back, then let the pipe empty
    task automatic drain_all();
        while (pixel_q.size() != 0 || i_in_valid || dest_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_pix rand_pix();
        t_pix px;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0: px[k] = '0;
                1: px[k] = '1;
                default: px[k] = CHAN_W'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic run_level(input int unsigned w, h, nc, n);
        bit split;
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, nc);
        split = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            if (split && i == n / 2) drain_all();
            pixel_q.push_back(rand_pix());
        end
        drain_all();
    endtask

    // sender: bursts with random gaps
    int burst_left = 8, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                filter_pixel({i_chan3_in, i_chan2_in, i_chan1_in, i_chan0_in});
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    t_pix px;
                    px = pixel_q.pop_front();
                    {i_chan3_in, i_chan2_in, i_chan1_in, i_chan0_in} <= px;
                    i_in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result; the stall pattern changes mode at random
    int stall_mode = 0, mode_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (dest_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d", $time, o_dest_x, o_dest_y);
                    errors++;
                end else begin
                    t_dest_pix e;
                    t_pix got;
                    e = dest_q.pop_front();
                    got = {o_chan3_out, o_chan2_out, o_chan1_out, o_chan0_out};
                    for (int k = 0; k < 4; k++) begin
                        if (got[k] !== e.chans[k]) begin
                            $display("%0t: chan%0d expected %h actual %h", $time, k,
                                     e.chans[k], got[k]);
                            errors++;
                        end
                    end
                    if (o_dest_x !== e.x) begin
                        $display("%0t: dest_x expected %0d actual %0d", $time, e.x, o_dest_x);
                        errors++;
                    end
                    if (o_dest_y !== e.y) begin
                        $display("%0t: dest_y expected %0d actual %0d", $time, e.y, o_dest_y);
                        errors++;
                    end
                    if (o_level_done !== e.done) begin
                        $display("%0t: level_done expected %0d actual %0d", $time, e.done,
                                 o_level_done);
                        errors++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned w, h, nc, n, budget;
        for (int i = 0; i < ACC_COLS * 4; i++) col_sum[i] = 0;
        for (int k = 0; k < 4; k++) row_sum[k] = 0;
        src_col = 0;
        src_row = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: 2x2, four channels, extreme pixels
        repeat (4) pixel_q.push_back('1);
        repeat (4) pixel_q.push_back('0);
        pixel_q.push_back({16'hffff, 16'h0000, 16'h0001, 16'hfffe});
        pixel_q.push_back({16'h0000, 16'hffff, 16'h8000, 16'h7fff});
        pixel_q.push_back({16'h5555, 16'haaaa, 16'hffff, 16'h0001});
        pixel_q.push_back({16'haaaa, 16'h5555, 16'h0000, 16'h8000});
        drain_all();
        // saturating sizes and channel counts, odd axes
        run_level(0, 1, 0, 8);
        run_level(3, 3, 7, 9);
        run_level(5, 2, 1, 10);
        run_level(3, 8191, 2, 24);
        run_level(2, 4095, 3, 20);

        budget = 0;
        while (budget < 1450) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 10);
            case ($urandom_range(0, 11))
                0: h = $urandom_range(0, 1);
                1: h = $urandom_range(4095, 8191);
                default: h = $urandom_range(2, 10);
            endcase
            nc = $urandom_range(0, 7);
            n = clampu(w, 2, 4096) * clampu(h, 2, 4096) * $urandom_range(1, 2);
            if (n > 300 || $urandom_range(0, 9) == 0) n = $urandom_range(1, 300);
            run_level(w, h, nc, n);
            budget += n;
        end

        // widest rows: saturated and odd widths at the top of the range
        run_level(8191, 1, 4, 40);
        run_level(4095, 2, 4, 40);

        drain_all();
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
